// ===== sv/assert_macros.svh =====
// assertion macros shared by the gated track association rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define GTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define GTA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/gta_pkg.sv =====
// types and constants of the gated track association block
package gta_pkg;

  localparam int POS_W    = 15;
  localparam int BRIGHT_W = 16;
  localparam int AREA_W   = 20;
  localparam int TAG_W    = 16;
  localparam int SLOT_W   = 8;
  localparam int SQ_W     = 2 * POS_W;

  localparam int RADIUS_W = 32;
  localparam int MARGIN_W = 15;
  localparam int EXTENT_W = 16;

  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = RADIUS_W;

  localparam logic [REG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXTENT = 2'd2;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 32'd357604;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 15'd720;
  localparam logic [EXTENT_W-1:0] EXTENT_RST = 16'd32768;

  // stored per entry besides the position
  typedef struct packed {
    logic [TAG_W-1:0]    blob_tag;
    logic [AREA_W-1:0]   blob_area;
    logic [BRIGHT_W-1:0] brightness;
  } payload_t;

  // one blob, also the word of the track table
  typedef struct packed {
    payload_t         pay;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_x;
  } blob_t;

  localparam int BLOB_W      = $bits(blob_t);
  localparam int IN_TDATA_W  = ((BLOB_W + 7) / 8) * 8;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              dropped_full;
    logic              appended;
    logic              replaced;
    logic              matched;
    logic              in_range;
  } result_t;

  localparam int RESULT_W    = $bits(result_t);
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius_sq;
    logic [MARGIN_W-1:0] margin;
    logic [EXTENT_W-1:0] extent;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic classify;
    logic issue;
    logic commit_hit;
    logic commit_miss;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_done;
    logic scan_busy;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/gta_ram.sv =====
// generic single write port ram with registered read
module gta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gta_ctrl.sv =====
// sequencing state machine of the gated track association block
`include "assert_macros.svh"

module gta_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  gta_pkg::sts_t sts_i,
  output gta_pkg::cmd_t cmd_o
);
  import gta_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CLASSIFY = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = s_valid_i;
        if (s_valid_i) begin
          state_d = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        cmd_o.classify = 1'b1;
        state_d        = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.issue = !sts_i.issue_done && !sts_i.hit;
        if (sts_i.hit) begin
          state_d = ST_HIT;
        end else if (sts_i.issue_done && !sts_i.scan_busy) begin
          state_d = ST_MISS;
        end
      end
      ST_HIT: begin
        cmd_o.commit_hit = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_MISS: begin
        cmd_o.commit_miss = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `GTA_ASSERT(a_commit_needs_room, (cmd_o.commit_hit || cmd_o.commit_miss) |-> sts_i.out_free, "commit while result register busy")
  `GTA_ASSERT_NEXT(a_load_then_classify, cmd_o.load, cmd_o.classify, "classify did not follow load")

endmodule

// ===== sv/gta_dp.sv =====
// datapath: blob capture, border test, table scan pipeline, write-back, result register
`include "assert_macros.svh"

module gta_dp #(
  parameter int TABLE_DEPTH = 256,
  parameter int IDX_W       = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  gta_pkg::cfg_t            cfg_i,
  input  gta_pkg::cmd_t            cmd_i,
  output gta_pkg::sts_t            sts_o,
  input  gta_pkg::blob_t           blob_i,
  input  logic                     first_i,
  output logic                     ram_re_o,
  output logic [IDX_W:0]           ram_raddr_o,
  input  gta_pkg::blob_t           ram_rdata_i,
  output logic                     ram_we_o,
  output logic [IDX_W:0]           ram_waddr_o,
  output gta_pkg::blob_t           ram_wdata_o,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output gta_pkg::result_t         m_result_o
);
  import gta_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // captured blob
  blob_t      blob_q;
  logic       first_q;

  // per item control
  logic             inside_q;
  logic             search_q;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] scan_idx_q;
  logic [CNT_W-1:0] main_cnt_q;
  logic [CNT_W-1:0] edge_cnt_q;

  // scan pipeline
  logic             v_a_q, v_b_q, hit_q;
  logic [IDX_W-1:0] idx_a_q, idx_b_q, hit_idx_q;
  logic [SQ_W-1:0]  sq_x_q, sq_y_q;
  payload_t         pay_b_q, hit_pay_q;

  logic             m_valid_q;
  result_t          m_res_q;

  // border test
  logic signed [EXTENT_W:0] hi_lim;
  logic                     x_in, y_in, in_border;

  always_comb begin
    hi_lim    = signed'({1'b0, cfg_i.extent}) - signed'({2'b00, cfg_i.margin});
    x_in      = (blob_q.pos_x >= cfg_i.margin) &&
                (signed'({2'b00, blob_q.pos_x}) <= hi_lim);
    y_in      = (blob_q.pos_y >= cfg_i.margin) &&
                (signed'({2'b00, blob_q.pos_y}) <= hi_lim);
    in_border = x_in && y_in;
  end

  // distance terms from the word just read
  logic [POS_W-1:0] ad_x, ad_y;
  logic [SQ_W-1:0]  sq_x, sq_y;

  always_comb begin
    ad_x = (blob_q.pos_x >= ram_rdata_i.pos_x) ? blob_q.pos_x - ram_rdata_i.pos_x
                                              : ram_rdata_i.pos_x - blob_q.pos_x;
    ad_y = (blob_q.pos_y >= ram_rdata_i.pos_y) ? blob_q.pos_y - ram_rdata_i.pos_y
                                              : ram_rdata_i.pos_y - blob_q.pos_y;
    sq_x = {{POS_W{1'b0}}, ad_x} * {{POS_W{1'b0}}, ad_x};
    sq_y = {{POS_W{1'b0}}, ad_y} * {{POS_W{1'b0}}, ad_y};
  end

  logic [SQ_W:0] d2;
  logic          hit_now;

  assign d2      = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign hit_now = v_b_q && ({{(RADIUS_W-SQ_W-1){1'b0}}, d2} <= cfg_i.radius_sq);

  // outcome
  logic    full, replace, app_we;
  result_t res_d;

  always_comb begin
    full    = (n_q == CNT_W'(TABLE_DEPTH));
    replace = blob_q.pay.brightness > hit_pay_q.brightness;
    app_we  = cmd_i.commit_miss && !full;
    res_d   = '0;
    res_d.in_range = inside_q;
    if (cmd_i.commit_hit) begin
      res_d.matched    = 1'b1;
      res_d.replaced   = replace;
      res_d.slot_index = SLOT_W'(hit_idx_q);
    end else begin
      res_d.dropped_full = full;
      res_d.appended     = !full;
      res_d.slot_index   = full ? '0 : SLOT_W'(n_q);
    end
  end

  // table ram access, edge table in the upper half
  assign ram_re_o    = cmd_i.issue;
  assign ram_raddr_o = {!inside_q, scan_idx_q[IDX_W-1:0]};
  assign ram_we_o    = cmd_i.commit_hit || app_we;
  assign ram_waddr_o = cmd_i.commit_hit ? {!inside_q, hit_idx_q}
                                        : {!inside_q, n_q[IDX_W-1:0]};

  always_comb begin
    ram_wdata_o = blob_q;
    if (cmd_i.commit_hit && !replace) begin
      ram_wdata_o.pay = hit_pay_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q   <= 1'b0;
      search_q   <= 1'b0;
      n_q        <= '0;
      scan_idx_q <= '0;
      main_cnt_q <= '0;
      edge_cnt_q <= '0;
      v_a_q      <= 1'b0;
      v_b_q      <= 1'b0;
      hit_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.classify) begin
        inside_q   <= in_border;
        search_q   <= !in_border || !first_q;
        n_q        <= in_border ? main_cnt_q : edge_cnt_q;
        scan_idx_q <= '0;
        v_a_q      <= 1'b0;
        v_b_q      <= 1'b0;
        hit_q      <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          scan_idx_q <= scan_idx_q + CNT_W'(1);
        end
        v_a_q <= cmd_i.issue;
        v_b_q <= v_a_q;
        if (!hit_q) begin
          hit_q <= hit_now;
        end
      end
      if (app_we) begin
        if (inside_q) begin
          main_cnt_q <= main_cnt_q + CNT_W'(1);
        end else begin
          edge_cnt_q <= edge_cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.commit_hit || cmd_i.commit_miss) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      blob_q  <= blob_i;
      first_q <= first_i;
    end
    idx_a_q <= scan_idx_q[IDX_W-1:0];
    idx_b_q <= idx_a_q;
    pay_b_q <= ram_rdata_i.pay;
    sq_x_q  <= sq_x;
    sq_y_q  <= sq_y;
    if (!hit_q && v_b_q) begin
      hit_idx_q <= idx_b_q;
      hit_pay_q <= pay_b_q;
    end
    if (cmd_i.commit_hit || cmd_i.commit_miss) begin
      m_res_q <= res_d;
    end
  end

  assign sts_o.issue_done = !search_q || (scan_idx_q == n_q);
  assign sts_o.scan_busy  = v_a_q || v_b_q;
  assign sts_o.hit        = hit_q;
  assign sts_o.out_free   = !m_valid_q || m_ready_i;

  assign m_valid_o  = m_valid_q;
  assign m_result_o = m_res_q;

  // terms of the checks below
  logic counts_ok, flags_ok, hit_keep;

  assign counts_ok = (main_cnt_q <= CNT_W'(TABLE_DEPTH)) &&
                     (edge_cnt_q <= CNT_W'(TABLE_DEPTH));
  assign flags_ok  = ($countones({m_res_q.matched, m_res_q.appended,
                                  m_res_q.dropped_full}) == 1) &&
                     (!m_res_q.replaced || m_res_q.matched);
  assign hit_keep  = hit_q && !cmd_i.classify;

  `GTA_ASSERT(a_count_bound, counts_ok, "table count beyond depth")
  `GTA_ASSERT_NEXT(a_hit_frozen, hit_keep, hit_q && $stable(hit_idx_q), "first match lost")
  `GTA_ASSERT(a_one_outcome, m_valid_q |-> flags_ok, "inconsistent result flags")

endmodule

// ===== sv/gated_track_association_core.sv =====
// top level of the gated track association block
//
//  channel   dir  handshake                      word
//  s_axis    in   s_axis_tvalid / s_axis_tready  one blob, tuser = first frame flag
//  m_axis    out  m_axis_tvalid / m_axis_tready  association result of one blob
//  cfg       in   cfg_we_i                       register write, no read-back
//
//  an accepted blob is scanned and committed before the next blob can be taken; the
//  scan reads the entries of the chosen table in order until the first match (all
//  stored ones when nothing matches); a blob with nothing to read (first-frame main
//  blob or empty table) reads no entry
//  the scan reads one stored entry per cycle from the single read port of the table ram
//  reset loads the default settings and clears both table counts; no clearing pass
//  a result waits in the output register while the next blob is taken in; a held
//  result stalls only the commit of the following blob
module gated_track_association_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // blob in, tdata from bit 0: pos_x, pos_y, brightness, blob_area, blob_tag, zero fill
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [gta_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: first_frame
  input  logic                               s_axis_tuser,
  // result out, tdata from bit 0: in_range, matched, replaced, appended,
  // dropped_full, slot_index, zero fill
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [gta_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [gta_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gta_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import gta_pkg::*;

  // entry index width, at least one bit
  localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // main table in the lower half of the ram, edge table in the upper half
  localparam int RAM_DEPTH = 2 * (2 ** IDX_W);

  // configuration registers
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS: cfg_d.radius_sq = cfg_wdata_i[RADIUS_W-1:0];
        REG_MARGIN: cfg_d.margin    = cfg_wdata_i[MARGIN_W-1:0];
        REG_EXTENT: cfg_d.extent    = cfg_wdata_i[EXTENT_W-1:0];
        default:    cfg_d           = cfg_q;  // unused index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius_sq <= RADIUS_RST;
      cfg_q.margin    <= MARGIN_RST;
      cfg_q.extent    <= EXTENT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cmd_t    cmd;
  sts_t    sts;
  blob_t   in_blob;
  result_t result;

  logic             ram_re, ram_we;
  logic [IDX_W:0]   ram_raddr, ram_waddr;
  blob_t            ram_rdata, ram_wdata;
  logic [BLOB_W-1:0] ram_rdata_raw;

  assign in_blob   = blob_t'(s_axis_tdata[BLOB_W-1:0]);
  assign ram_rdata = blob_t'(ram_rdata_raw);

  gta_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gta_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .blob_i      (in_blob),
    .first_i     (s_axis_tuser),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_result_o  (result)
  );

  // both track tables share one ram, one entry read per scan cycle
  gta_ram #(
    .WIDTH (BLOB_W),
    .DEPTH (RAM_DEPTH)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, result};

endmodule

// ===== verif/tb_gated_track_association_core.sv =====
// testbench of gated_track_association_core: directed and random blobs checked against a predictor
`timescale 1ns / 100ps

module tb_gated_track_association_core;
  import gta_pkg::*;

  localparam int TRACK_DEPTH    = 256;
  localparam int POS_MAX        = (1 << POS_W) - 1;
  localparam int STALL_LIMIT    = 20000;  // cycles with no word moving on either side
  localparam int RX_HOLD_CYCLES = 3000;   // long receiver hold-off, fills the block up
  localparam int SETTLE_CYCLES  = 8;      // quiet time before a register write

  // register index beyond the three real registers, writes must be ignored
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {TBL_EDGE = 0, TBL_MAIN = 1} table_e;
  typedef enum logic [1:0] {RX_STREAM, RX_HALF, RX_SPARSE} rx_mode_e;

  // ---------------------------------------------------------------------------
  // track association predictor: own copy of both tables and of the registers,
  // works out the association outcome of every accepted blob and checks the
  // result words in order
  // ---------------------------------------------------------------------------
  class association_predictor;
    logic [RADIUS_W-1:0] radius_sq = RADIUS_RST;
    logic [MARGIN_W-1:0] margin    = MARGIN_RST;
    logic [EXTENT_W-1:0] extent    = EXTENT_RST;
    blob_t               tracks[2][TRACK_DEPTH];
    int unsigned         fill[2];
    result_t             pending_outcomes[$];
    int unsigned         fault_count;

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_RADIUS: radius_sq = val[RADIUS_W-1:0];
        REG_MARGIN: margin = val[MARGIN_W-1:0];
        REG_EXTENT: extent = val[EXTENT_W-1:0];
        default: ;
      endcase
    endfunction

    // lower bound is the margin, upper bound extent minus margin, both inclusive
    function bit inside_border(logic [POS_W-1:0] c);
      return longint'(c) >= longint'(margin) &&
             longint'(c) <= longint'(extent) - longint'(margin);
    endfunction

    function void take_blob(blob_t b, logic first_frame);
      result_t     r;
      table_e      t;
      bit          scan;
      bit          hit;
      int unsigned n;
      longint      dx;
      longint      dy;
      r = '0;
      r.in_range = inside_border(b.pos_x) && inside_border(b.pos_y);
      t = r.in_range ? TBL_MAIN : TBL_EDGE;
      // first frame skips the search on the main table only
      scan = !(r.in_range && first_frame);
      n = fill[t];
      hit = 1'b0;
      if (scan) begin
        for (int unsigned i = 0; i < n; i++) begin
          dx = longint'(b.pos_x) - longint'(tracks[t][i].pos_x);
          dy = longint'(b.pos_y) - longint'(tracks[t][i].pos_y);
          if (dx * dx + dy * dy <= longint'(radius_sq)) begin
            hit = 1'b1;
            r.matched = 1'b1;
            r.slot_index = SLOT_W'(i);
            // strictly brighter takes the whole entry, otherwise position only
            if (b.pay.brightness > tracks[t][i].pay.brightness) begin
              r.replaced = 1'b1;
              tracks[t][i].pay = b.pay;
            end
            tracks[t][i].pos_x = b.pos_x;
            tracks[t][i].pos_y = b.pos_y;
            break;
          end
        end
      end
      if (!hit) begin
        if (n >= TRACK_DEPTH) begin
          r.dropped_full = 1'b1;
        end else begin
          tracks[t][n] = b;
          fill[t] = n + 1;
          r.appended = 1'b1;
          r.slot_index = SLOT_W'(n);
        end
      end
      pending_outcomes = {pending_outcomes, r};
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      result_t     want;
      result_t     got;
      logic [31:0] want_f[7];
      logic [31:0] got_f[7];
      string       names[7] = '{"in_range", "matched", "replaced", "appended",
                                "dropped_full", "slot_index", "zero fill"};
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result word %h arrived with no blob waiting", $time, word);
        fault_count++;
        return;
      end
      want = pending_outcomes.pop_front();
      got = result_t'(word[RESULT_W-1:0]);
      want_f = '{want.in_range, want.matched, want.replaced, want.appended,
                 want.dropped_full, want.slot_index, 0};
      got_f = '{got.in_range, got.matched, got.replaced, got.appended,
                got.dropped_full, got.slot_index, word[OUT_TDATA_W-1:RESULT_W]};
      foreach (want_f[k]) begin
        if (got_f[k] !== want_f[k]) begin
          $display("%0t: %s expected %0d actual %0d", $time, names[k], want_f[k], got_f[k]);
          fault_count++;
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                    s_axis_tuser  = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    cfg_we_i      = 1'b0;
  logic [REG_IDX_W-1:0]    cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i   = '0;

  association_predictor    predictor;

  // sender burst bookkeeping
  int unsigned             burst_left    = 0;

  // receiver hold-off request, bumped by the stimulus, served by the receiver
  int unsigned             rx_hold_req   = 0;
  int unsigned             rx_hold_seen  = 0;
  int unsigned             rx_hold_left  = 0;
  rx_mode_e                rx_mode       = RX_STREAM;
  int unsigned             rx_mode_left  = 0;

  int unsigned             quiet_cycles  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gated_track_association_core #(
    .TABLE_DEPTH (TRACK_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // monitor: handshakes are sampled at the rising edge, before any update of
  // that edge, so a blob is predicted and a result checked exactly once
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predictor.take_blob(blob_t'(s_axis_tdata[BLOB_W-1:0]), s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        predictor.check_result(m_axis_tdata);
      end
    end
  end

  // watchdog: too long with no word moving on either side ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("[gated_track_association_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern that switches between streaming, half rate and
  // sparse acceptance, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 2));
        rx_mode_left <= $urandom_range(20, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_STREAM: m_axis_tready <= 1'b1;
        RX_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 0);
        default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sender: offers one blob word, waits for it to be taken, then either keeps
  // valid up for the rest of the burst or idles for a random gap
  // ---------------------------------------------------------------------------
  task automatic send_blob(input blob_t b, input logic first_frame);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'(b);
    s_axis_tuser <= first_frame;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      // mostly short gaps, now and then a longer one that can outlast a full table scan
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 24);
    end
  endtask

  task automatic send_fields(input int x, input int y, input int bright, input int area,
                             input int tag, input logic first_frame);
    blob_t b;
    b.pos_x = POS_W'(x);
    b.pos_y = POS_W'(y);
    b.pay.brightness = BRIGHT_W'(bright);
    b.pay.blob_area = AREA_W'(area);
    b.pay.blob_tag = TAG_W'(tag);
    send_blob(b, first_frame);
  endtask

  // stop offering and wait until every result is back and the block is quiet
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (predictor.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    predictor.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // all three registers plus a junk write to the spare index, block idle
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] radius,
                                input logic [CFG_DATA_W-1:0] margin,
                                input logic [CFG_DATA_W-1:0] extent);
    cfg_write(REG_SPARE, $urandom());
    cfg_write(REG_RADIUS, radius);
    cfg_write(REG_MARGIN, margin);
    cfg_write(REG_EXTENT, extent);
    cfg_we_i <= 1'b0;
  endtask

  // coordinate, biased toward the border bounds of the current setting
  function automatic logic [POS_W-1:0] pick_coord();
    int v;
    int m;
    int e;
    m = int'(predictor.margin);
    e = int'(predictor.extent);
    case ($urandom_range(0, 15))
      0:       v = m;
      1:       v = m - 1;
      2:       v = e - m;
      3:       v = e - m + 1;
      4:       v = 0;
      5:       v = POS_MAX;
      default: v = $urandom_range(0, POS_MAX);
    endcase
    if (v < 0 || v > POS_MAX) v = $urandom_range(0, POS_MAX);
    return POS_W'(v);
  endfunction

  // move a stored coordinate by up to span sixteenths, clamped to the field
  function automatic logic [POS_W-1:0] nudge(input logic [POS_W-1:0] c, input int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > POS_MAX) v = POS_MAX;
    return POS_W'(v);
  endfunction

  // a track continuation near a stored entry, or a fresh blob anywhere
  task automatic gen_item(input int near_pct, input int span,
                          output blob_t b, output logic first_frame);
    int    t;
    blob_t base;
    b.pos_x = pick_coord();
    b.pos_y = pick_coord();
    b.pay.brightness = BRIGHT_W'($urandom());
    b.pay.blob_area = AREA_W'($urandom());
    b.pay.blob_tag = TAG_W'($urandom());
    first_frame = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 99) < near_pct) begin
      t = $urandom_range(0, 1);
      if (predictor.fill[t] == 0) t = 1 - t;
      if (predictor.fill[t] != 0) begin
        base = predictor.tracks[t][$urandom_range(0, predictor.fill[t] - 1)];
        b.pos_x = nudge(base.pos_x, span);
        b.pos_y = nudge(base.pos_y, span);
        // equal, one brighter, or random brightness against the stored entry
        case ($urandom_range(0, 2))
          0:       b.pay.brightness = base.pay.brightness;
          1:       b.pay.brightness = base.pay.brightness + 1'b1;
          default: ;
        endcase
      end
    end
  endtask

  task automatic random_phase(input int count, input int near_pct, input int span,
                              input int hold_at);
    blob_t b;
    logic  first_frame;
    for (int k = 0; k < count; k++) begin
      // long receiver hold-off while the sender keeps offering
      if (k == hold_at) rx_hold_req <= rx_hold_req + 1;
      gen_item(near_pct, span, b, first_frame);
      send_blob(b, first_frame);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    predictor = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings: margin 720, upper bound 32048, radius 598 squared
    // first frame appends to the main table even on top of an existing entry
    send_fields(720, 720, 100, 1, 1, 1'b1);
    send_fields(720, 720, 100, 2, 2, 1'b1);
    send_fields(32048, 32048, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 1'b1);
    // equal brightness moves only, brighter replaces, dimmer moves only
    send_fields(730, 725, 100, 3, 3, 1'b0);
    send_fields(735, 725, 101, 4, 4, 1'b0);
    send_fields(740, 725, 0, 5, 5, 1'b0);
    // empty edge table appends, then first frame still searches the edge table
    send_fields(719, 5000, 50, 6, 6, 1'b0);
    send_fields(32049, 100, 50, 7, 7, 1'b1);
    send_fields(32040, 110, 60, 8, 8, 1'b1);
    // field extremes on the edge table
    send_fields(0, 0, 0, 0, 0, 1'b0);
    send_fields(POS_MAX, POS_MAX, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 1'b0);
    send_fields(POS_MAX, POS_MAX, 16'hFFFF, 9, 9, 1'b0);
    // distance exactly on the radius matches, one sixteenth beyond does not
    send_fields(31450, 32048, 5, 10, 10, 1'b0);
    send_fields(30851, 32048, 5, 11, 11, 1'b0);
    send_fields(31873, 31625, 5, 12, 12, 1'b0);
    // one coordinate outside the border is enough for the edge table
    send_fields(100, 16000, 7, 13, 13, 1'b0);
    send_fields(16000, 32700, 7, 14, 14, 1'b0);
    // two entries within reach, the earlier one wins
    send_fields(730, 722, 200, 15, 15, 1'b0);
    // alternating bit patterns
    send_fields(15'h5555, 15'h2AAA, 16'hAAAA, 20'h55555, 16'hAAAA, 1'b0);
    send_fields(15'h2AAA, 15'h5555, 16'h5555, 20'hAAAAA, 16'h5555, 1'b1);
    drain_block();

    // reset settings, mixed tracks and fresh blobs, long receiver hold-off
    random_phase(350, 50, 300, 120);
    drain_block();

    // zero radius, zero margin: all blobs inside, the main table fills up and drops
    apply_settings(0, 0, 32768);
    random_phase(220, 30, 0, -1);
    drain_block();

    // margin above extent minus margin: nothing inside, the edge table fills up
    apply_settings(0, 16384, 16384);
    random_phase(220, 30, 0, -1);
    drain_block();

    // widest radius, largest margin and extent: only the top coordinate is inside
    apply_settings('1, POS_MAX, 16'hFFFF);
    random_phase(100, 20, 0, -1);
    drain_block();

    // zero extent: only the origin is inside
    apply_settings($urandom(), 0, 0);
    random_phase(80, 40, 100, -1);

    // random settings, upper bits of the write data included
    repeat (2) begin
      drain_block();
      apply_settings($urandom_range(0, 2000000), $urandom(), $urandom());
      random_phase(80, 50, 200, -1);
    end
    drain_block();

    // back to the reset settings
    apply_settings(RADIUS_RST, MARGIN_RST, EXTENT_RST);
    random_phase(200, 60, 300, -1);
    drain_block();

    // room for any stray result word
    repeat (20) @(posedge clk_i);
    if (predictor.fault_count == 0) begin
      $display("[gated_track_association_core] OK");
    end else begin
      $display("[gated_track_association_core] ERROR");
    end
    $finish;
  end

endmodule
